[rtl/core/assert_macros.svh]
// Assertion macros shared by the page buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/cpb_pkg.sv]
// Shared types and constants of the page buffer lookup block.
package cpb_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 20;
    localparam int PAGE_ID_W   = 20;
    localparam int SLOT_OUT_W  = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PAGE_ID_W-1:0] page_id;
        logic                 page_kind;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [PAGE_ID_W-1:0]  victim_page_id;
        logic                  victim_page_kind;
    } t_rsp;

endpackage

[rtl/core/cpb_fifo.sv]
// Small synchronous queue used on the request and result sides.
module cpb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cpb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[rtl/core/cpb_engine.sv]
// Back end: tag compare, slot fill and CLOCK sweep for one request at a time.
`include "assert_macros.svh"

module cpb_engine #(
    parameter int SLOTS   = cpb_pkg::SLOTS_DEF,
    parameter int ID_BITS = cpb_pkg::ID_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_empty,
    output logic          o_req_pop,
    input  cpb_pkg::t_req i_req,
    input  logic          i_res_full,
    output logic          o_res_push,
    output cpb_pkg::t_rsp o_rsp
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PID_W  = cpb_pkg::PAGE_ID_W;
    localparam int SOUT_W = cpb_pkg::SLOT_OUT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_DECIDE = 4'b0100,
        S_SWEEP  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [ID_BITS-1:0]  r_id;
    logic                r_kind;
    logic [SLOTS-1:0]    r_match, n_match;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [SLOT_W-1:0]   r_hand, n_hand;
    logic [SLOTS-1:0]    r_ref, n_ref;
    logic [ID_BITS-1:0]  r_tag_id [SLOTS];
    logic                r_tag_kind [SLOTS];

    logic [PID_W+ID_BITS-1:0]  w_id_ext;
    logic [ID_BITS-1:0]        w_id_in;
    logic [SLOT_W-1:0]         w_hit_pos;
    logic                      w_any_hit;
    logic [SLOT_W-1:0]         w_hand_nxt;
    logic                      w_tag_we;
    logic [SLOT_W-1:0]         w_pos;
    logic [SLOT_W+SOUT_W-1:0]  w_pos_ext;
    logic [ID_BITS+PID_W-1:0]  w_vid_ext;
    logic                      w_hit, w_evict;

    // Truncate or zero-extend the page id to the stored tag width.
    assign w_id_ext = {{ID_BITS{1'b0}}, i_req.page_id};
    assign w_id_in  = w_id_ext[ID_BITS-1:0];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_match[i] = (CNT_W'(i) < r_fill) && (r_tag_id[i] == r_id)
                         && (r_tag_kind[i] == r_kind);
        end
    end

    // Lowest matching slot wins.
    always_comb begin
        w_hit_pos = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_pos = SLOT_W'(i);
            end
        end
    end

    assign w_any_hit  = |r_match;
    assign w_hand_nxt = (r_hand == SLOT_W'(SLOTS - 1)) ? '0 : r_hand + 1'b1;
    assign w_vid_ext  = {{PID_W{1'b0}}, r_tag_id[r_hand]};
    assign w_pos_ext  = {{SOUT_W{1'b0}}, w_pos};

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_hand     = r_hand;
        n_ref      = r_ref;
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;
        w_tag_we   = 1'b0;
        w_pos      = w_hit_pos;
        w_hit      = 1'b0;
        w_evict    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_req_empty && !i_res_full) begin
                    o_req_pop = 1'b1;
                    n_state   = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_any_hit) begin
                    w_hit            = 1'b1;
                    n_ref[w_hit_pos] = 1'b1;
                    o_res_push       = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_fill < CNT_W'(SLOTS)) begin
                    w_pos        = r_fill[SLOT_W-1:0];
                    w_tag_we     = 1'b1;
                    n_ref[w_pos] = 1'b1;
                    n_fill       = r_fill + 1'b1;
                    o_res_push   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                w_pos = r_hand;
                if (r_ref[r_hand]) begin
                    // Second chance: clear and move on.
                    n_ref[r_hand] = 1'b0;
                    n_hand        = w_hand_nxt;
                end else begin
                    w_evict       = 1'b1;
                    w_tag_we      = 1'b1;
                    n_ref[r_hand] = 1'b1;
                    o_res_push    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rsp.hit              = w_hit;
        o_rsp.slot             = w_pos_ext[SOUT_W-1:0];
        o_rsp.evicted          = w_evict;
        o_rsp.victim_page_id   = w_evict ? w_vid_ext[PID_W-1:0] : '0;
        o_rsp.victim_page_kind = w_evict ? r_tag_kind[r_hand] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_hand  <= '0;
            r_ref   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_hand  <= n_hand;
            r_ref   <= n_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_id   <= w_id_in;
            r_kind <= i_req.page_kind;
        end
        r_match <= n_match;
        if (w_tag_we) begin
            r_tag_id[w_pos]   <= r_id;
            r_tag_kind[w_pos] <= r_kind;
        end
    end

    `ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(SLOTS))
    `ASSERT_NOW(a_sweep_full, i_clk, i_rst_n, r_state == S_SWEEP, r_fill == CNT_W'(SLOTS))
    `ASSERT_NOW(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full)
    `ASSERT_NEXT(a_sweep_clear, i_clk, i_rst_n, (r_state == S_SWEEP) && r_ref[r_hand],
                 !r_ref[$past(r_hand)] && (r_state == S_SWEEP))

endmodule

[rtl/core/clock_page_buffer_lookup_unit.sv]
// Top level of the page buffer lookup block with CLOCK replacement.
//
// Usage: requests enter through a queue-style port: drive i_req and raise
// push; the transaction completes on a rising edge with push high and full
// low. Each request yields exactly one result on o_rsp, in request order.
// A result is offered while empty is low and leaves on an edge with pop high.
// Engine: a hit or a miss into a free slot passes IDLE (pop), MATCH (tag
// compare) and DECIDE (push to the result queue); a miss on a full buffer
// goes on to SWEEP, where the hand clears each set reference bit it passes
// and takes the first slot with a clear bit as victim. The engine takes one
// request at a time, and pops only while the result queue is not full.
// Reset (synchronous, active low) empties both queues, clears the fill count,
// the hand and all reference bits; tag contents are left as they are.
// When the receiver stalls, results collect in the result queue; once it is
// full the engine holds, and the request queue then fills and raises full.
module clock_page_buffer_lookup_unit #(
    parameter int SLOTS   = cpb_pkg::SLOTS_DEF,
    parameter int ID_BITS = cpb_pkg::ID_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  cpb_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output cpb_pkg::t_rsp o_rsp
);

    localparam int REQ_W = $bits(cpb_pkg::t_req);
    localparam int RSP_W = $bits(cpb_pkg::t_rsp);

    logic                 w_req_empty;
    logic                 w_req_pop;
    logic [REQ_W-1:0]     w_req_bits;
    cpb_pkg::t_req        w_req;
    logic                 w_res_full;
    logic                 w_res_push;
    cpb_pkg::t_rsp        w_rsp;
    logic [RSP_W-1:0]     w_rsp_bits;

    // Front: buffer incoming transactions so the engine can stall on its own.
    cpb_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (cpb_pkg::QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (i_req),
        .o_full  (full),
        .i_pop   (w_req_pop),
        .o_rdata (w_req_bits),
        .o_empty (w_req_empty)
    );

    assign w_req = w_req_bits;

    // Back: lookup, fill and replacement.
    cpb_engine #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (w_req_empty),
        .o_req_pop   (w_req_pop),
        .i_req       (w_req),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_rsp       (w_rsp)
    );

    // Hold finished results until the receiver takes them.
    cpb_fifo #(
        .WIDTH (RSP_W),
        .DEPTH (cpb_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_rsp),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_rsp_bits),
        .o_empty (empty)
    );

    assign o_rsp = w_rsp_bits;

endmodule
